[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the design checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low)
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/qpe_pkg.sv]
// ---------------------------------------------------------------------------
// qpe_pkg
// Types, character codes and helpers for the quoted-printable encoder.
// ---------------------------------------------------------------------------
package qpe_pkg;

    localparam int MaxResults = 16;
    localparam int CountW     = 5;

    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_HT = 8'h09;
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    localparam logic [7:0] LIMIT_RESET = 8'd73;

    typedef logic [MaxResults-1:0][7:0] seq_t;

    typedef struct packed {
        logic [7:0] line_count;
        logic [7:0] held_space;
        logic       held_space_valid;
        logic       held_cr;
        logic       after_hard_break;
    } state_t;

    function automatic logic needs_escape(logic [7:0] c);
        return (c > CH_TILDE) || (c == CH_EQ) ||
               ((c < CH_SP) && (c != CH_HT) && (c != CH_CR) && (c != CH_LF));
    endfunction

    function automatic logic [7:0] hex_digit(logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'h0, v};
        end else begin
            r = 8'h37 + {4'h0, v};
        end
        return r;
    endfunction

    function automatic logic [7:0] sat_add(logic [7:0] a, logic [1:0] k);
        logic [8:0] s;
        s = {1'b0, a} + {7'b0, k};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

endpackage

[design/qpe_expand.sv]
// ---------------------------------------------------------------------------
// qpe_expand
// Expands one message byte into its output character sequence and next state.
// ---------------------------------------------------------------------------
module qpe_expand (
    input  logic [7:0]      in_byte,
    input  logic            last_byte,
    input  logic [7:0]      line_limit,
    input  qpe_pkg::state_t state_in,
    output qpe_pkg::state_t state_out,
    output qpe_pkg::seq_t   seq,
    output logic [qpe_pkg::CountW-1:0] seq_count
);

    always_comb begin
        qpe_pkg::state_t st;
        qpe_pkg::seq_t   sq;
        logic [qpe_pkg::CountW-1:0] n;
        logic [7:0]      c;
        logic            do_fresh;

        st       = state_in;
        sq       = '0;
        n        = '0;
        c        = in_byte;
        do_fresh = 1'b0;

        if (st.held_space_valid && st.held_cr) begin
            st.held_space_valid = 1'b0;
            st.held_cr          = 1'b0;
            if (c == qpe_pkg::CH_LF) begin
                // space before CR LF: escape it, then hard break
                sq[n[3:0]] = qpe_pkg::CH_EQ;                     n = n + 1'b1;
                sq[n[3:0]] = qpe_pkg::hex_digit(st.held_space[7:4]); n = n + 1'b1;
                sq[n[3:0]] = qpe_pkg::hex_digit(st.held_space[3:0]); n = n + 1'b1;
                sq[n[3:0]] = qpe_pkg::CH_CR;                     n = n + 1'b1;
                sq[n[3:0]] = qpe_pkg::CH_LF;                     n = n + 1'b1;
                st.line_count       = '0;
                st.after_hard_break = 1'b1;
            end else begin
                sq[n[3:0]] = st.held_space; n = n + 1'b1;
                st.line_count       = qpe_pkg::sat_add(st.line_count, 2'd1);
                if (st.line_count != 8'd0 && st.line_count >= line_limit) begin
                    sq[n[3:0]] = qpe_pkg::CH_EQ; n = n + 1'b1;
                    sq[n[3:0]] = qpe_pkg::CH_CR; n = n + 1'b1;
                    sq[n[3:0]] = qpe_pkg::CH_LF; n = n + 1'b1;
                    st.line_count = '0;
                end
                sq[n[3:0]] = qpe_pkg::CH_CR; n = n + 1'b1;
                st.line_count       = qpe_pkg::sat_add(st.line_count, 2'd1);
                st.after_hard_break = 1'b0;
                do_fresh            = 1'b1;
            end
        end else if (st.held_space_valid) begin
            if (c == qpe_pkg::CH_LF) begin
                st.held_space_valid = 1'b0;
                sq[n[3:0]] = qpe_pkg::CH_EQ;                     n = n + 1'b1;
                sq[n[3:0]] = qpe_pkg::hex_digit(st.held_space[7:4]); n = n + 1'b1;
                sq[n[3:0]] = qpe_pkg::hex_digit(st.held_space[3:0]); n = n + 1'b1;
                sq[n[3:0]] = qpe_pkg::CH_CR;                     n = n + 1'b1;
                sq[n[3:0]] = qpe_pkg::CH_LF;                     n = n + 1'b1;
                st.line_count       = '0;
                st.after_hard_break = 1'b1;
            end else if (c == qpe_pkg::CH_CR && !last_byte) begin
                st.held_cr = 1'b1;
            end else begin
                st.held_space_valid = 1'b0;
                sq[n[3:0]] = st.held_space; n = n + 1'b1;
                st.line_count       = qpe_pkg::sat_add(st.line_count, 2'd1);
                st.after_hard_break = 1'b0;
                do_fresh            = 1'b1;
            end
        end else if (st.held_cr) begin
            st.held_cr = 1'b0;
            if (c == qpe_pkg::CH_LF) begin
                sq[n[3:0]] = qpe_pkg::CH_CR; n = n + 1'b1;
                sq[n[3:0]] = qpe_pkg::CH_LF; n = n + 1'b1;
                st.line_count       = '0;
                st.after_hard_break = 1'b1;
            end else begin
                // lone CR passes literally
                sq[n[3:0]] = qpe_pkg::CH_CR; n = n + 1'b1;
                st.line_count       = qpe_pkg::sat_add(st.line_count, 2'd1);
                st.after_hard_break = 1'b0;
                do_fresh            = 1'b1;
            end
        end else begin
            do_fresh = 1'b1;
        end

        if (do_fresh) begin
            if (st.line_count != 8'd0 && st.line_count >= line_limit) begin
                sq[n[3:0]] = qpe_pkg::CH_EQ; n = n + 1'b1;
                sq[n[3:0]] = qpe_pkg::CH_CR; n = n + 1'b1;
                sq[n[3:0]] = qpe_pkg::CH_LF; n = n + 1'b1;
                st.line_count       = '0;
                st.after_hard_break = 1'b0;
            end
            if (c == qpe_pkg::CH_LF) begin
                sq[n[3:0]] = qpe_pkg::CH_CR; n = n + 1'b1;
                sq[n[3:0]] = qpe_pkg::CH_LF; n = n + 1'b1;
                st.line_count       = '0;
                st.after_hard_break = 1'b1;
            end else if (c == qpe_pkg::CH_CR && !last_byte) begin
                st.held_cr = 1'b1;
            end else if (qpe_pkg::needs_escape(c)) begin
                sq[n[3:0]] = qpe_pkg::CH_EQ;            n = n + 1'b1;
                sq[n[3:0]] = qpe_pkg::hex_digit(c[7:4]); n = n + 1'b1;
                sq[n[3:0]] = qpe_pkg::hex_digit(c[3:0]); n = n + 1'b1;
                st.line_count       = qpe_pkg::sat_add(st.line_count, 2'd3);
                st.after_hard_break = 1'b0;
            end else if ((c == qpe_pkg::CH_SP || c == qpe_pkg::CH_HT) && !last_byte) begin
                st.held_space       = c;
                st.held_space_valid = 1'b1;
            end else begin
                // plain byte, or a final CR / space / tab
                sq[n[3:0]] = c; n = n + 1'b1;
                st.line_count       = qpe_pkg::sat_add(st.line_count, 2'd1);
                st.after_hard_break = 1'b0;
            end
        end

        if (last_byte) begin
            if (!st.after_hard_break) begin
                sq[n[3:0]] = qpe_pkg::CH_EQ; n = n + 1'b1;
                sq[n[3:0]] = qpe_pkg::CH_CR; n = n + 1'b1;
                sq[n[3:0]] = qpe_pkg::CH_LF; n = n + 1'b1;
            end
            st = '0;
        end

        state_out = st;
        seq       = sq;
        seq_count = n;
    end

endmodule

[design/quoted_printable_encoder_top.sv]
// With the output idle, the first character of a transaction is presented once the
// byte has passed the input register and its expansion is loaded into the buffer.
// A new input byte is loaded only once the previous byte's characters have drained
// through the single-character output port (an escaped byte expands to 3 of them).
// Input is accepted while the previous expansion is still draining.
// Reset (aresetn low, synchronous) clears the line state and sets line_limit to 73.
// ---------------------------------------------------------------------------
// quoted_printable_encoder_top
// Streaming quoted-printable encoder with a configurable soft line limit.
// ---------------------------------------------------------------------------
module quoted_printable_encoder_top (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_wen,
    input  logic [7:0] cfg_wdata,      // line_limit
    // message bytes in
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,        // [7:0] in_byte
    input  logic       s_tlast,        // last_byte
    // encoded characters out
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,        // [7:0] out_byte
    output logic       m_tlast,        // run_last
    output logic [0:0] m_tuser         // [0] message_end
);

    logic [7:0]                    line_limit_reg;
    qpe_pkg::state_t               state_reg;
    qpe_pkg::state_t               state_next;
    logic                          in_valid_reg;
    logic [7:0]                    in_byte_reg;
    logic                          in_last_reg;
    qpe_pkg::seq_t                 buf_reg;
    qpe_pkg::seq_t                 seq_next;
    logic [qpe_pkg::CountW-1:0]    buf_cnt_reg;
    logic [qpe_pkg::CountW-1:0]    seq_count_next;
    logic                          buf_end_reg;
    logic                          load;
    logic                          out_take;

    qpe_expand u_expand (
        .in_byte    (in_byte_reg),
        .last_byte  (in_last_reg),
        .line_limit (line_limit_reg),
        .state_in   (state_reg),
        .state_out  (state_next),
        .seq        (seq_next),
        .seq_count  (seq_count_next)
    );

    assign out_take = m_tvalid && m_tready;
    // load when the character buffer is empty or its final character leaves now
    assign load     = in_valid_reg &&
                      ((buf_cnt_reg == '0) ||
                       ((buf_cnt_reg == qpe_pkg::CountW'(1)) && m_tready));
    assign s_tready = !in_valid_reg || load;

    assign m_tvalid   = (buf_cnt_reg != '0);
    assign m_tdata    = buf_reg[0];
    assign m_tlast    = (buf_cnt_reg == qpe_pkg::CountW'(1));
    assign m_tuser[0] = buf_end_reg && (buf_cnt_reg == qpe_pkg::CountW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_limit_reg <= qpe_pkg::LIMIT_RESET;
            state_reg      <= '0;
            in_valid_reg   <= 1'b0;
            buf_cnt_reg    <= '0;
        end else begin
            if (cfg_wen) begin
                line_limit_reg <= cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (load) begin
                in_valid_reg <= 1'b0;
            end
            if (load) begin
                state_reg   <= state_next;
                buf_cnt_reg <= seq_count_next;
            end else if (out_take) begin
                buf_cnt_reg <= buf_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (load) begin
            buf_reg     <= seq_next;
            buf_end_reg <= in_last_reg;
        end else if (out_take) begin
            buf_reg <= {8'h00, buf_reg[qpe_pkg::MaxResults-1:1]};
        end
    end

endmodule

[design/qpe_checker.sv]
// ---------------------------------------------------------------------------
// qpe_checker
// Port-level checks on the encoder output stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qpe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [0:0] m_tuser
);

    // stalled output must hold
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output changed while stalled")

    // encoded text is 7-bit
    `ASSERT_CLK(a_ascii, aclk, aresetn, m_tvalid |-> !m_tdata[7], "non-ASCII character emitted")

    // message end is always the end of a run
    `ASSERT_CLK(a_end_is_last, aclk, aresetn, m_tvalid && m_tuser[0] |-> m_tlast, "message end without run end")

    // every message closes with a line break (soft or hard)
    `ASSERT_CLK(a_end_lf, aclk, aresetn, m_tvalid && m_tuser[0] |-> m_tdata == 8'h0A, "message does not end in LF")

endmodule

bind quoted_printable_encoder_top qpe_checker u_qpe_checker (.*);
